@@ rtl/ase_pkg.sv @@
// Package for the ascending sort engine.
// Holds the beat structs and the control struct shared by the core and its cells.
// No dependencies.
package ase_pkg;

  localparam int unsigned ValueW = 32;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } in_beat_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_res;
    logic                     last_res;
    logic                     overflow;
  } out_beat_t;

  typedef struct packed {
    logic                     ins;
    logic                     shl;
    logic signed [ValueW-1:0] value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    StLoad = 2'b01,
    StEmit = 2'b10
  } state_e;

endpackage

@@ rtl/ase_cell.sv @@
// One cell of the sorting chain: holds one element and trades it with its neighbors.
// Depends on ase_pkg.
module ase_cell (
  input  logic                                   clk_i,
  input  ase_pkg::cell_ctl_t                     ctl_i,
  input  logic                                   occ_i,
  input  logic signed [ase_pkg::ValueW-1:0]      left_val_i,
  input  logic                                   left_gt_i,
  input  logic signed [ase_pkg::ValueW-1:0]      right_val_i,
  output logic signed [ase_pkg::ValueW-1:0]      val_o,
  output logic                                   gt_o
);

  logic signed [ase_pkg::ValueW-1:0] val_q, val_d;

  // A free cell or one holding a larger value gives way to the new element.
  assign gt_o = !occ_i || (val_q > ctl_i.value);

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins && gt_o) begin
      val_d = left_gt_i ? left_val_i : ctl_i.value;
    end else if (ctl_i.shl) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

@@ rtl/ascending_sort_engine_core.sv @@
// Top level of the ascending sort engine: a chain of insertion cells and its sequencer.
// Depends on ase_pkg and ase_cell.
//
// Elements arrive on item_i and are taken at each rising edge where start_i is high
// and busy_o is low. While the array loads, one element can be taken every cycle and
// is inserted in place along the cell chain in that same cycle. An element that finds
// all MAX_ITEMS cells full is dropped and the overflow flag is set for this array.
// The beat flagged last is inserted too unless all cells are full, and from the next
// cycle the stored elements leave in ascending order on res_o, one beat per cycle with
// res_valid_o high, by shifting the chain toward cell zero. During emission busy_o is
// high. The final beat carries last_res, and busy_o falls in the cycle after it, so
// the next array can start right away. Equal values leave in arrival order. There is
// no backpressure on results. Reset empties the chain and clears the overflow flag.
module ascending_sort_engine_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ase_pkg::in_beat_t  item_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output ase_pkg::out_beat_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  ase_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               drop_q, drop_d;
  logic               accept;
  logic               full;
  ase_pkg::cell_ctl_t ctl;

  logic signed [ase_pkg::ValueW-1:0] vals [MAX_ITEMS];
  logic                              gts  [MAX_ITEMS];

  assign accept = start_i && (state_q == ase_pkg::StLoad);
  assign full   = (count_q == CntW'(MAX_ITEMS));

  assign ctl.ins   = accept && !full;
  assign ctl.shl   = (state_q == ase_pkg::StEmit);
  assign ctl.value = item_i.value;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ase_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (count_q > CntW'(i)),
      .left_val_i  ((i == 0) ? vals[0] : vals[(i == 0) ? 0 : i - 1]),
      .left_gt_i   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
      .right_val_i (vals[(i == MAX_ITEMS - 1) ? i : i + 1]),
      .val_o       (vals[i]),
      .gt_o        (gts[i])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    drop_d  = drop_q;
    case (state_q)
      ase_pkg::StLoad: begin
        if (accept) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (item_i.last) begin
            state_d = ase_pkg::StEmit;
          end
        end
      end
      ase_pkg::StEmit: begin
        count_d = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          state_d = ase_pkg::StLoad;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = ase_pkg::StLoad;
        count_d = '0;
        drop_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ase_pkg::StLoad;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  assign busy_o          = (state_q == ase_pkg::StEmit);
  assign res_valid_o     = (state_q == ase_pkg::StEmit);
  assign res_o.value_res = vals[0];
  assign res_o.last_res  = (count_q == CntW'(1));
  assign res_o.overflow  = drop_q;

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ase_pkg::StEmit) |-> (count_q != '0))
    else $error("Emission with an empty chain.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ITEMS))
    else $error("Element count exceeds capacity.");

  a_last_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.last) |=> res_valid_o)
    else $error("Final element did not start emission.");

  a_final_beat_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_res) |=> (!busy_o && count_q == '0 && !drop_q))
    else $error("Block did not return to empty after the final beat.");

endmodule

@@ tb/ase_sort_checker.sv @@
// Checker for the ascending sort engine: watches the element and result beats.
// It keeps its own sorted copy of each array and compares every result beat.
// Depends on ase_pkg.
module ase_sort_checker #(
  parameter int unsigned MaxItems = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  ase_pkg::in_beat_t  item_i,
  input  logic               res_valid_i,
  input  ase_pkg::out_beat_t res_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);

  logic signed [ase_pkg::ValueW-1:0] held_q[$];
  logic                              dropped;
  ase_pkg::out_beat_t                awaited_q[$];

  // Equal values go behind the ones already held, so arrival order is kept.
  function automatic void store_element(input logic signed [ase_pkg::ValueW-1:0] v);
    int unsigned pos;
    pos = held_q.size();
    while (pos > 0 && held_q[pos-1] > v) pos--;
    held_q.insert(pos, v);
  endfunction

  function automatic void release_sorted();
    ase_pkg::out_beat_t b;
    for (int unsigned k = 0; k < held_q.size(); k++) begin
      b.value_res = held_q[k];
      b.last_res  = (k + 1 == held_q.size());
      b.overflow  = dropped;
      awaited_q.push_back(b);
    end
    held_q.delete();
    dropped = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ase_pkg::out_beat_t want;
    if (!rst_ni) begin
      held_q.delete();
      awaited_q.delete();
      dropped = 1'b0;
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (res_valid_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got value %0d last %0b ovf %0b",
                   $time, res_i.value_res, res_i.last_res, res_i.overflow);
          fail_count_o++;
        end else begin
          want = awaited_q.pop_front();
          checked_o++;
          if (res_i.value_res !== want.value_res) begin
            $display("%0t: value_res expected %0d, got %0d",
                     $time, want.value_res, res_i.value_res);
            fail_count_o++;
          end
          if (res_i.last_res !== want.last_res) begin
            $display("%0t: last_res expected %0b, got %0b", $time, want.last_res, res_i.last_res);
            fail_count_o++;
          end
          if (res_i.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b, got %0b", $time, want.overflow, res_i.overflow);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        if (held_q.size() < MaxItems) begin
          store_element(item_i.value);
        end else begin
          dropped = 1'b1;
        end
        if (item_i.last) begin
          release_sorted();
        end
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

@@ tb/tb.sv @@
// Top of the ascending sort engine testbench: clock, reset, element stimulus and verdict.
// Results are predicted and compared by ase_sort_checker.
// Depends on ase_pkg, ascending_sort_engine_core and ase_sort_checker.
module tb;

  localparam int unsigned MaxItems    = 64;
  localparam int unsigned BeatTarget  = 410;
  localparam int unsigned CalmTail    = 60;
  localparam int unsigned StallLimit  = 300;
  localparam int unsigned DrainCycles = 8;

  localparam logic signed [ase_pkg::ValueW-1:0] MinVal =
    {1'b1, {(ase_pkg::ValueW-1){1'b0}}};
  localparam logic signed [ase_pkg::ValueW-1:0] MaxVal =
    {1'b0, {(ase_pkg::ValueW-1){1'b1}}};

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start_i = 1'b0;
  ase_pkg::in_beat_t  item_i  = '0;
  logic               busy_o;
  logic               res_valid_o;
  ase_pkg::out_beat_t res_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned beats_sent;
  int unsigned arrays_sent;
  int unsigned overflow_arrays;
  int unsigned array_len;
  int unsigned stall_cycles;
  bit          idle_on;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ascending_sort_engine_core #(
    .MAX_ITEMS(MaxItems)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  ase_sort_checker #(
    .MaxItems(MaxItems)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .item_i      (item_i),
    .res_valid_i (res_valid_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic signed [ase_pkg::ValueW-1:0] pick_value();
    int narrow;
    narrow = $urandom_range(0, 16);
    case ($urandom_range(0, 9))
      0:       return MinVal;
      1:       return MaxVal;
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4, 5: return narrow - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_elem(input logic signed [ase_pkg::ValueW-1:0] v, input logic is_last);
    if (idle_on && beats_sent + CalmTail < BeatTarget && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= '{value: v, last: is_last};
    do @(posedge clk_i); while (busy_o);
    beats_sent++;
    array_len++;
    if (is_last) begin
      arrays_sent++;
      if (array_len > MaxItems) overflow_arrays++;
      array_len = 0;
      idle_on = $urandom_range(0, 1);
    end
  endtask

  initial begin
    int unsigned len;
    idle_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_elem(MinVal, 1'b1);
    send_elem(MaxVal, 1'b1);
    send_elem(MaxVal, 1'b0);
    send_elem(MinVal, 1'b1);
    send_elem(0, 1'b0);
    send_elem(-1, 1'b0);
    send_elem(1, 1'b0);
    send_elem(-1, 1'b0);
    send_elem(0, 1'b1);
    for (int i = 5; i >= 1; i--) send_elem(i, i == 1);
    for (int i = 1; i <= 3; i++) send_elem(i, i == 3);

    // One array that exactly fills the store, then one whose last beat is dropped.
    for (int unsigned i = 0; i < MaxItems; i++) send_elem(pick_value(), i == MaxItems - 1);
    for (int unsigned i = 0; i < MaxItems + 3; i++) send_elem(pick_value(), i == MaxItems + 2);

    while (beats_sent < BeatTarget) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 10);
      end else begin
        len = $urandom_range(MaxItems - 4, MaxItems + 6);
      end
      for (int unsigned i = 0; i < len; i++) send_elem(pick_value(), i == len - 1);
    end
    start_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sorted %0d arrays from %0d element beats, %0d of them past capacity.",
             arrays_sent, beats_sent, overflow_arrays);
    $display("Compared %0d result beats; %0d still outstanding.", checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
